@@ rtl/rvdec_pkg.sv @@
package rvdec_pkg;

	localparam int COUNT_WIDTH = 32;
	localparam int TOTAL_WIDTH = 32;

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [5:0]             op_t;

	// major opcodes
	localparam logic [6:0] OPC_OP     = 7'h33;
	localparam logic [6:0] OPC_OP32   = 7'h3B;
	localparam logic [6:0] OPC_OPIMM  = 7'h13;
	localparam logic [6:0] OPC_OPIMM32 = 7'h1B;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_JAL    = 7'h6F;
	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;
	localparam logic [6:0] OPC_SYSTEM = 7'h73;

	localparam logic [6:0] F7_ALT    = 7'h20;
	localparam logic [5:0] F6_SRAI   = 6'h10;
	localparam logic [11:0] IMM_ECALL  = 12'h000;
	localparam logic [11:0] IMM_EBREAK = 12'h001;

	// operation codes
	localparam op_t OP_INVALID = 6'd0;
	localparam op_t OP_ADD     = 6'd1;
	localparam op_t OP_SUB     = 6'd2;
	localparam op_t OP_SLL     = 6'd3;
	localparam op_t OP_SLT     = 6'd4;
	localparam op_t OP_SLTU    = 6'd5;
	localparam op_t OP_XOR     = 6'd6;
	localparam op_t OP_SRL     = 6'd7;
	localparam op_t OP_SRA     = 6'd8;
	localparam op_t OP_OR      = 6'd9;
	localparam op_t OP_AND     = 6'd10;
	localparam op_t OP_ADDW    = 6'd11;
	localparam op_t OP_SUBW    = 6'd12;
	localparam op_t OP_SLLW    = 6'd13;
	localparam op_t OP_SRLW    = 6'd14;
	localparam op_t OP_SRAW    = 6'd15;
	localparam op_t OP_ADDI    = 6'd16;
	localparam op_t OP_SLTI    = 6'd17;
	localparam op_t OP_SLTIU   = 6'd18;
	localparam op_t OP_XORI    = 6'd19;
	localparam op_t OP_ORI     = 6'd20;
	localparam op_t OP_ANDI    = 6'd21;
	localparam op_t OP_SLLI    = 6'd22;
	localparam op_t OP_SRLI    = 6'd23;
	localparam op_t OP_SRAI    = 6'd24;
	localparam op_t OP_ADDIW   = 6'd25;
	localparam op_t OP_SLLIW   = 6'd26;
	localparam op_t OP_SRLIW   = 6'd27;
	localparam op_t OP_SRAIW   = 6'd28;
	localparam op_t OP_LB      = 6'd29;
	localparam op_t OP_LH      = 6'd30;
	localparam op_t OP_LW      = 6'd31;
	localparam op_t OP_LD      = 6'd32;
	localparam op_t OP_LBU     = 6'd33;
	localparam op_t OP_LHU     = 6'd34;
	localparam op_t OP_LWU     = 6'd35;
	localparam op_t OP_SB      = 6'd36;
	localparam op_t OP_SH      = 6'd37;
	localparam op_t OP_SW      = 6'd38;
	localparam op_t OP_SD      = 6'd39;
	localparam op_t OP_BEQ     = 6'd40;
	localparam op_t OP_BNE     = 6'd41;
	localparam op_t OP_BLT     = 6'd42;
	localparam op_t OP_BGE     = 6'd43;
	localparam op_t OP_BLTU    = 6'd44;
	localparam op_t OP_BGEU    = 6'd45;
	localparam op_t OP_JAL     = 6'd46;
	localparam op_t OP_JALR    = 6'd47;
	localparam op_t OP_LUI     = 6'd48;
	localparam op_t OP_AUIPC   = 6'd49;
	localparam op_t OP_ECALL   = 6'd50;
	localparam op_t OP_EBREAK  = 6'd51;

	typedef struct packed {
		op_t         operation;
		logic [1:0]  register_count;
		logic [4:0]  reg_slot_a;
		logic [4:0]  reg_slot_b;
		logic [4:0]  reg_slot_c;
		logic        has_immediate;
		logic [31:0] immediate;
	} dec_result_t;

	// low bits of a count, zero-extended when the count is narrower
	function automatic logic [TOTAL_WIDTH-1:0] total_bits(input count_t cnt);
		logic [63:0] ext;
		ext = 64'(cnt);
		return ext[TOTAL_WIDTH-1:0];
	endfunction

endpackage

@@ rtl/rv64i_instruction_decoder_top.sv @@
// channel | handshake           | payload
// --------+---------------------+------------------------------------------------
// in      | in_valid, in_ready  | instruction_word, program_counter
// out     | out_valid, out_ready| operation, register_count, reg_slot_a/b/c,
//         |                     | has_immediate, immediate, pc_out, raw_out,
//         |                     | decoded_total, invalid_total
//
// from accept to result: input register, then decode into the output register
// one word per cycle sustained; in_ready drops only when both registers are full and
// out_ready is low
// arst_n clears both valid bits and the two saturating word counters
module rv64i_instruction_decoder_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [31:0]        instruction_word,
	input  logic [63:0]        program_counter,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [5:0]         operation,
	output logic [1:0]         register_count,
	output logic [4:0]         reg_slot_a,
	output logic [4:0]         reg_slot_b,
	output logic [4:0]         reg_slot_c,
	output logic               has_immediate,
	output logic signed [31:0] immediate,
	output logic [63:0]        pc_out,
	output logic [31:0]        raw_out,
	output logic [31:0]        decoded_total,
	output logic [31:0]        invalid_total
);

	logic        valid_s1;
	logic [31:0] word_s1;
	logic [63:0] pc_s1;

	logic                   valid_s2;
	rvdec_pkg::dec_result_t dec_s2;
	logic [63:0]            pc_s2;
	logic [31:0]            word_s2;
	logic [31:0]            decoded_s2;
	logic [31:0]            invalid_s2;

	rvdec_pkg::dec_result_t dec;
	rvdec_pkg::count_t      decoded_next;
	rvdec_pkg::count_t      invalid_next;
	logic                   advance;
	logic                   s2_free;

	assign s2_free  = !valid_s2 || out_ready;
	assign advance  = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;

	rvdec_decode u_decode (
		.word   (word_s1),
		.result (dec)
	);

	rvdec_counters u_counters (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.invalid      (dec.operation == rvdec_pkg::OP_INVALID),
		.decoded_next (decoded_next),
		.invalid_next (invalid_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1 <= instruction_word;
			pc_s1   <= program_counter;
		end
		if (advance) begin
			dec_s2     <= dec;
			pc_s2      <= pc_s1;
			word_s2    <= word_s1;
			decoded_s2 <= rvdec_pkg::total_bits(decoded_next);
			invalid_s2 <= rvdec_pkg::total_bits(invalid_next);
		end
	end

	assign out_valid      = valid_s2;
	assign operation      = dec_s2.operation;
	assign register_count = dec_s2.register_count;
	assign reg_slot_a     = dec_s2.reg_slot_a;
	assign reg_slot_b     = dec_s2.reg_slot_b;
	assign reg_slot_c     = dec_s2.reg_slot_c;
	assign has_immediate  = dec_s2.has_immediate;
	assign immediate      = dec_s2.immediate;
	assign pc_out         = pc_s2;
	assign raw_out        = word_s2;
	assign decoded_total  = decoded_s2;
	assign invalid_total  = invalid_s2;

endmodule

@@ rtl/rvdec_decode.sv @@
module rvdec_decode (
	input  logic [31:0]               word,
	output rvdec_pkg::dec_result_t    result
);

	logic [6:0] opc;
	logic [2:0] f3;
	logic       alt;
	logic [4:0] rd;
	logic [4:0] rs1;
	logic [4:0] rs2;
	rvdec_pkg::op_t op;

	assign opc = word[6:0];
	assign f3  = word[14:12];
	assign alt = (word[31:25] == rvdec_pkg::F7_ALT);
	assign rd  = word[11:7];
	assign rs1 = word[19:15];
	assign rs2 = word[24:20];

	always_comb begin
		op = rvdec_pkg::OP_INVALID;
		case (opc)
			rvdec_pkg::OPC_OP: begin
				case (f3)
					3'd0: op = alt ? rvdec_pkg::OP_SUB : rvdec_pkg::OP_ADD;
					3'd1: op = rvdec_pkg::OP_SLL;
					3'd2: op = rvdec_pkg::OP_SLT;
					3'd3: op = rvdec_pkg::OP_SLTU;
					3'd4: op = rvdec_pkg::OP_XOR;
					3'd5: op = alt ? rvdec_pkg::OP_SRA : rvdec_pkg::OP_SRL;
					3'd6: op = rvdec_pkg::OP_OR;
					default: op = rvdec_pkg::OP_AND;
				endcase
			end
			rvdec_pkg::OPC_OP32: begin
				case (f3)
					3'd0: op = alt ? rvdec_pkg::OP_SUBW : rvdec_pkg::OP_ADDW;
					3'd1: op = rvdec_pkg::OP_SLLW;
					3'd5: op = alt ? rvdec_pkg::OP_SRAW : rvdec_pkg::OP_SRLW;
					default: op = rvdec_pkg::OP_INVALID;
				endcase
			end
			rvdec_pkg::OPC_OPIMM: begin
				case (f3)
					3'd0: op = rvdec_pkg::OP_ADDI;
					3'd1: op = rvdec_pkg::OP_SLLI;
					3'd2: op = rvdec_pkg::OP_SLTI;
					3'd3: op = rvdec_pkg::OP_SLTIU;
					3'd4: op = rvdec_pkg::OP_XORI;
					// srai by funct6 so shamt bit 5 is ignored
					3'd5: op = (word[31:26] == rvdec_pkg::F6_SRAI) ?
						rvdec_pkg::OP_SRAI : rvdec_pkg::OP_SRLI;
					3'd6: op = rvdec_pkg::OP_ORI;
					default: op = rvdec_pkg::OP_ANDI;
				endcase
			end
			rvdec_pkg::OPC_OPIMM32: begin
				case (f3)
					3'd0: op = rvdec_pkg::OP_ADDIW;
					3'd1: op = rvdec_pkg::OP_SLLIW;
					3'd5: op = alt ? rvdec_pkg::OP_SRAIW : rvdec_pkg::OP_SRLIW;
					default: op = rvdec_pkg::OP_INVALID;
				endcase
			end
			rvdec_pkg::OPC_LOAD: begin
				case (f3)
					3'd0: op = rvdec_pkg::OP_LB;
					3'd1: op = rvdec_pkg::OP_LH;
					3'd2: op = rvdec_pkg::OP_LW;
					3'd3: op = rvdec_pkg::OP_LD;
					3'd4: op = rvdec_pkg::OP_LBU;
					3'd5: op = rvdec_pkg::OP_LHU;
					3'd6: op = rvdec_pkg::OP_LWU;
					default: op = rvdec_pkg::OP_INVALID;
				endcase
			end
			rvdec_pkg::OPC_STORE: begin
				case (f3)
					3'd0: op = rvdec_pkg::OP_SB;
					3'd1: op = rvdec_pkg::OP_SH;
					3'd2: op = rvdec_pkg::OP_SW;
					3'd3: op = rvdec_pkg::OP_SD;
					default: op = rvdec_pkg::OP_INVALID;
				endcase
			end
			rvdec_pkg::OPC_BRANCH: begin
				case (f3)
					3'd0: op = rvdec_pkg::OP_BEQ;
					3'd1: op = rvdec_pkg::OP_BNE;
					3'd4: op = rvdec_pkg::OP_BLT;
					3'd5: op = rvdec_pkg::OP_BGE;
					3'd6: op = rvdec_pkg::OP_BLTU;
					3'd7: op = rvdec_pkg::OP_BGEU;
					default: op = rvdec_pkg::OP_INVALID;
				endcase
			end
			rvdec_pkg::OPC_JALR: begin
				op = (f3 == 3'd0) ? rvdec_pkg::OP_JALR : rvdec_pkg::OP_INVALID;
			end
			rvdec_pkg::OPC_JAL:   op = rvdec_pkg::OP_JAL;
			rvdec_pkg::OPC_LUI:   op = rvdec_pkg::OP_LUI;
			rvdec_pkg::OPC_AUIPC: op = rvdec_pkg::OP_AUIPC;
			rvdec_pkg::OPC_SYSTEM: begin
				if (f3 == 3'd0 && rd == 5'd0 && rs1 == 5'd0) begin
					if (word[31:20] == rvdec_pkg::IMM_ECALL) begin
						op = rvdec_pkg::OP_ECALL;
					end else if (word[31:20] == rvdec_pkg::IMM_EBREAK) begin
						op = rvdec_pkg::OP_EBREAK;
					end
				end
			end
			default: op = rvdec_pkg::OP_INVALID;
		endcase
	end

	always_comb begin
		result = '0;
		result.operation = op;
		if (op >= rvdec_pkg::OP_ADD && op <= rvdec_pkg::OP_SRAW) begin
			result.reg_slot_a     = rd;
			result.reg_slot_b     = rs1;
			result.reg_slot_c     = rs2;
			result.register_count = 2'd3;
		end else if ((op >= rvdec_pkg::OP_ADDI && op <= rvdec_pkg::OP_LWU) ||
				op == rvdec_pkg::OP_JALR) begin
			result.reg_slot_a     = rd;
			result.reg_slot_b     = rs1;
			result.register_count = 2'd2;
			result.has_immediate  = 1'b1;
			result.immediate      = {{20{word[31]}}, word[31:20]};
		end else if (op >= rvdec_pkg::OP_SB && op <= rvdec_pkg::OP_SD) begin
			result.reg_slot_a     = rs1;
			result.reg_slot_b     = rs2;
			result.register_count = 2'd2;
			result.has_immediate  = 1'b1;
			result.immediate      = {{20{word[31]}}, word[31:25], word[11:7]};
		end else if (op >= rvdec_pkg::OP_BEQ && op <= rvdec_pkg::OP_BGEU) begin
			result.reg_slot_a     = rs1;
			result.reg_slot_b     = rs2;
			result.register_count = 2'd2;
			result.has_immediate  = 1'b1;
			result.immediate      = {{19{word[31]}}, word[31], word[7], word[30:25],
				word[11:8], 1'b0};
		end else if (op == rvdec_pkg::OP_LUI || op == rvdec_pkg::OP_AUIPC) begin
			result.reg_slot_a     = rd;
			result.register_count = 2'd1;
			result.has_immediate  = 1'b1;
			result.immediate      = {word[31:12], 12'd0};
		end else if (op == rvdec_pkg::OP_JAL) begin
			result.reg_slot_a     = rd;
			result.register_count = 2'd1;
			result.has_immediate  = 1'b1;
			result.immediate      = {{11{word[31]}}, word[31], word[19:12], word[20],
				word[30:21], 1'b0};
		end
	end

endmodule

@@ rtl/rvdec_counters.sv @@
module rvdec_counters (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic                invalid,
	output rvdec_pkg::count_t   decoded_next,
	output rvdec_pkg::count_t   invalid_next
);

	rvdec_pkg::count_t decoded_q;
	rvdec_pkg::count_t invalid_q;

	// saturating increments, including the word now moving to the output
	assign decoded_next = (&decoded_q) ? decoded_q : decoded_q + 1'b1;
	assign invalid_next = (invalid && !(&invalid_q)) ? invalid_q + 1'b1 : invalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decoded_q <= '0;
			invalid_q <= '0;
		end else if (advance) begin
			decoded_q <= decoded_next;
			invalid_q <= invalid_next;
		end
	end

endmodule

@@ tb/tb.sv @@
module tb;
	import rvdec_pkg::*;

	localparam logic [2:0] F3_BASE = 3'd0;
	localparam logic [2:0] F3_SHR = 3'd5;
	localparam int LONG_HOLD_CYCLES = 80;

	localparam op_t ALU_OPS [8] = '{OP_ADD, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_OR, OP_AND};
	localparam op_t IMM_OPS [8] = '{OP_ADDI, OP_SLLI, OP_SLTI, OP_SLTIU, OP_XORI, OP_SRLI, OP_ORI,
		OP_ANDI};
	localparam op_t WORD_OPS [8] = '{OP_ADDW, OP_SLLW, OP_INVALID, OP_INVALID, OP_INVALID, OP_SRLW,
		OP_INVALID, OP_INVALID};
	localparam op_t IMMW_OPS [8] = '{OP_ADDIW, OP_SLLIW, OP_INVALID, OP_INVALID, OP_INVALID,
		OP_SRLIW, OP_INVALID, OP_INVALID};
	localparam op_t LOAD_OPS [8] = '{OP_LB, OP_LH, OP_LW, OP_LD, OP_LBU, OP_LHU, OP_LWU, OP_INVALID};
	localparam op_t STORE_OPS [8] = '{OP_SB, OP_SH, OP_SW, OP_SD, OP_INVALID, OP_INVALID,
		OP_INVALID, OP_INVALID};
	localparam op_t BRANCH_OPS [8] = '{OP_BEQ, OP_BNE, OP_INVALID, OP_INVALID, OP_BLT, OP_BGE,
		OP_BLTU, OP_BGEU};
	localparam logic [6:0] NOISE_OPCS [7] = '{OPC_OP32, OPC_OPIMM32, OPC_LOAD, OPC_STORE,
		OPC_BRANCH, OPC_JALR, OPC_SYSTEM};

	typedef struct packed {
		op_t         operation;
		logic [1:0]  register_count;
		logic [4:0]  slot_a;
		logic [4:0]  slot_b;
		logic [4:0]  slot_c;
		logic        has_imm;
		logic [31:0] immediate;
		logic [63:0] pc;
		logic [31:0] raw;
		logic [31:0] decoded_total;
		logic [31:0] invalid_total;
	} decode_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [31:0]        instruction_word = '0;
	logic [63:0]        program_counter = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [5:0]         operation;
	logic [1:0]         register_count;
	logic [4:0]         reg_slot_a;
	logic [4:0]         reg_slot_b;
	logic [4:0]         reg_slot_c;
	logic               has_immediate;
	logic signed [31:0] immediate;
	logic [63:0]        pc_out;
	logic [31:0]        raw_out;
	logic [31:0]        decoded_total;
	logic [31:0]        invalid_total;

	decode_t     pending_decodes [$];
	count_t      words_decoded = '0;
	count_t      words_invalid = '0;
	int          mismatches = 0;
	int          results_checked = 0;
	int          invalid_results = 0;
	int          input_stalls = 0;
	int          output_stalls = 0;
	logic [63:0] ops_seen = '0;

	logic quiet = 1'b0;
	logic long_hold_req = 1'b0;
	int   long_hold_left = 0;
	int   stall_left = 0;
	int   mode_cycles = 0;
	logic busy = 1'b0;

	rv64i_instruction_decoder_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.instruction_word(instruction_word),
		.program_counter(program_counter),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.operation(operation),
		.register_count(register_count),
		.reg_slot_a(reg_slot_a),
		.reg_slot_b(reg_slot_b),
		.reg_slot_c(reg_slot_c),
		.has_immediate(has_immediate),
		.immediate(immediate),
		.pc_out(pc_out),
		.raw_out(raw_out),
		.decoded_total(decoded_total),
		.invalid_total(invalid_total)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic op_t operation_of(input logic [31:0] w);
		logic [2:0] f3;
		logic alt;
		op_t op;
		f3 = w[14:12];
		alt = (w[31:25] == F7_ALT);
		op = OP_INVALID;
		case (w[6:0])
			OPC_OP: begin
				op = ALU_OPS[f3];
				if (alt && f3 == F3_BASE) op = OP_SUB;
				if (alt && f3 == F3_SHR) op = OP_SRA;
			end
			OPC_OP32: begin
				op = WORD_OPS[f3];
				if (alt && f3 == F3_BASE) op = OP_SUBW;
				if (alt && f3 == F3_SHR) op = OP_SRAW;
			end
			OPC_OPIMM: begin
				op = IMM_OPS[f3];
				if (f3 == F3_SHR && w[31:26] == F6_SRAI) op = OP_SRAI;
			end
			OPC_OPIMM32: begin
				op = IMMW_OPS[f3];
				if (alt && f3 == F3_SHR) op = OP_SRAIW;
			end
			OPC_LOAD: op = LOAD_OPS[f3];
			OPC_STORE: op = STORE_OPS[f3];
			OPC_BRANCH: op = BRANCH_OPS[f3];
			OPC_JALR: if (f3 == F3_BASE) op = OP_JALR;
			OPC_JAL: op = OP_JAL;
			OPC_LUI: op = OP_LUI;
			OPC_AUIPC: op = OP_AUIPC;
			OPC_SYSTEM: begin
				if (f3 == F3_BASE && w[11:7] == 5'd0 && w[19:15] == 5'd0) begin
					if (w[31:20] == IMM_ECALL) op = OP_ECALL;
					else if (w[31:20] == IMM_EBREAK) op = OP_EBREAK;
				end
			end
			default: ;
		endcase
		return op;
	endfunction

	// advances the word counters and queues what the decoder must return
	function automatic void decode_word(input logic [31:0] w, input logic [63:0] pc);
		decode_t d;
		d = '0;
		d.operation = operation_of(w);
		d.pc = pc;
		d.raw = w;
		if (words_decoded != '1) words_decoded++;
		if (d.operation == OP_INVALID && words_invalid != '1) words_invalid++;
		if (d.operation >= OP_ADD && d.operation <= OP_SRAW) begin
			d.register_count = 2'd3;
			d.slot_a = w[11:7];
			d.slot_b = w[19:15];
			d.slot_c = w[24:20];
		end else if ((d.operation >= OP_ADDI && d.operation <= OP_LWU) || d.operation == OP_JALR) begin
			d.register_count = 2'd2;
			d.slot_a = w[11:7];
			d.slot_b = w[19:15];
			d.has_imm = 1'b1;
			d.immediate = {{20{w[31]}}, w[31:20]};
		end else if (d.operation >= OP_SB && d.operation <= OP_SD) begin
			d.register_count = 2'd2;
			d.slot_a = w[19:15];
			d.slot_b = w[24:20];
			d.has_imm = 1'b1;
			d.immediate = {{20{w[31]}}, w[31:25], w[11:7]};
		end else if (d.operation >= OP_BEQ && d.operation <= OP_BGEU) begin
			d.register_count = 2'd2;
			d.slot_a = w[19:15];
			d.slot_b = w[24:20];
			d.has_imm = 1'b1;
			d.immediate = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
		end else if (d.operation == OP_LUI || d.operation == OP_AUIPC) begin
			d.register_count = 2'd1;
			d.slot_a = w[11:7];
			d.has_imm = 1'b1;
			d.immediate = {w[31:12], 12'h000};
		end else if (d.operation == OP_JAL) begin
			d.register_count = 2'd1;
			d.slot_a = w[11:7];
			d.has_imm = 1'b1;
			d.immediate = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
		end
		d.decoded_total = 32'(words_decoded);
		d.invalid_total = 32'(words_invalid);
		pending_decodes.insert(pending_decodes.size(), d);
	endfunction

	// well-formed encoding of one operation, other fields random
	function automatic logic [31:0] make_word(input op_t op);
		logic [31:0] w;
		logic [6:0] opc;
		logic [2:0] f3;
		logic [6:0] f7;
		logic [6:0] plain_f7;
		w = $urandom;
		opc = OPC_OP;
		f3 = w[14:12];
		f7 = w[31:25];
		plain_f7 = ($urandom_range(0, 1) == 0) ? 7'h00 : 7'($urandom);
		if (plain_f7 == F7_ALT) plain_f7 = 7'h00;
		for (int i = 0; i < 8; i++) begin
			if (ALU_OPS[i] == op) begin
				opc = OPC_OP;
				f3 = 3'(i);
				f7 = plain_f7;
			end
			if (WORD_OPS[i] == op) begin
				opc = OPC_OP32;
				f3 = 3'(i);
				f7 = plain_f7;
			end
			if (IMM_OPS[i] == op) begin
				opc = OPC_OPIMM;
				f3 = 3'(i);
			end
			if (IMMW_OPS[i] == op) begin
				opc = OPC_OPIMM32;
				f3 = 3'(i);
			end
			if (LOAD_OPS[i] == op) begin
				opc = OPC_LOAD;
				f3 = 3'(i);
			end
			if (STORE_OPS[i] == op) begin
				opc = OPC_STORE;
				f3 = 3'(i);
			end
			if (BRANCH_OPS[i] == op) begin
				opc = OPC_BRANCH;
				f3 = 3'(i);
			end
		end
		case (op)
			OP_SUB, OP_SRA: begin
				opc = OPC_OP;
				f3 = (op == OP_SUB) ? F3_BASE : F3_SHR;
				f7 = F7_ALT;
			end
			OP_SUBW, OP_SRAW: begin
				opc = OPC_OP32;
				f3 = (op == OP_SUBW) ? F3_BASE : F3_SHR;
				f7 = F7_ALT;
			end
			OP_SRAIW: begin
				opc = OPC_OPIMM32;
				f3 = F3_SHR;
				f7 = F7_ALT;
			end
			OP_SRLIW: f7 = plain_f7;
			OP_SRAI: begin
				opc = OPC_OPIMM;
				f3 = F3_SHR;
				f7 = {F6_SRAI, w[25]};
			end
			OP_SRLI: f7 = {(w[31:26] == F6_SRAI) ? 6'h00 : w[31:26], w[25]};
			OP_JALR: begin
				opc = OPC_JALR;
				f3 = F3_BASE;
			end
			OP_JAL: return {w[31:7], OPC_JAL};
			OP_LUI: return {w[31:7], OPC_LUI};
			OP_AUIPC: return {w[31:7], OPC_AUIPC};
			OP_ECALL: return {IMM_ECALL, 13'd0, OPC_SYSTEM};
			OP_EBREAK: return {IMM_EBREAK, 13'd0, OPC_SYSTEM};
			default: ;
		endcase
		return {f7, w[24:15], f3, w[11:7], opc};
	endfunction

	// mostly near misses under opcodes that have holes
	function automatic logic [31:0] noise_word();
		logic [31:0] w;
		logic [6:0] opc;
		w = $urandom;
		opc = NOISE_OPCS[$urandom_range(0, 6)];
		if ($urandom_range(0, 3) == 0) return w;
		do begin
			w = $urandom;
			w[6:0] = opc;
			if (opc == OPC_SYSTEM && w[31]) w[19:7] = '0;
		end while (operation_of(w) != OP_INVALID);
		return w;
	endfunction

	function automatic logic [63:0] random_pc();
		return {32'($urandom), 32'($urandom)};
	endfunction

	task automatic send_word(input logic [31:0] w, input logic [63:0] pc, input int gap_odds);
		in_valid <= 1'b1;
		instruction_word <= w;
		program_counter <= pc;
		do @(posedge clk); while (in_ready !== 1'b1);
		decode_word(w, pc);
		@(negedge clk);
		if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_decodes.size() != 0) @(negedge clk);
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("mismatch in %s at word %0d: got %h, expected %h", what, results_checked, got, want);
		mismatches++;
	endtask

	task automatic test_directed();
		send_word(32'h0000_0000, 64'h0, 3);
		send_word(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 3);
		send_word({7'h00, 5'd31, 5'd31, 3'd0, 5'd31, OPC_OP}, random_pc(), 3);
		send_word({F7_ALT, 5'd1, 5'd2, 3'd0, 5'd3, OPC_OP}, random_pc(), 3);
		send_word({7'h01, 5'd4, 5'd5, 3'd0, 5'd6, OPC_OP}, random_pc(), 3);
		send_word({F7_ALT, 5'd7, 5'd8, 3'd5, 5'd9, OPC_OP}, random_pc(), 3);
		send_word({7'h7F, 5'd31, 5'd31, 3'd7, 5'd0, OPC_OP}, random_pc(), 3);
		send_word({F7_ALT, 5'd1, 5'd1, 3'd0, 5'd1, OPC_OP32}, random_pc(), 3);
		send_word({7'h00, 5'd1, 5'd1, 3'd2, 5'd1, OPC_OP32}, random_pc(), 3);
		send_word({12'h7FF, 5'd1, 3'd0, 5'd2, OPC_OPIMM}, random_pc(), 3);
		send_word({12'h800, 5'd31, 3'd0, 5'd31, OPC_OPIMM}, random_pc(), 3);
		// arithmetic shift with shamt bit 5 set must stay arithmetic
		send_word({F6_SRAI, 1'b1, 5'd31, 5'd10, 3'd5, 5'd11, OPC_OPIMM}, random_pc(), 3);
		send_word({6'h00, 1'b1, 5'd31, 5'd10, 3'd5, 5'd11, OPC_OPIMM}, random_pc(), 3);
		send_word({F7_ALT, 5'd5, 5'd6, 3'd5, 5'd7, OPC_OPIMM32}, random_pc(), 3);
		send_word({7'h21, 5'd5, 5'd6, 3'd5, 5'd7, OPC_OPIMM32}, random_pc(), 3);
		send_word({12'hFFF, 5'd3, 3'd6, 5'd4, OPC_LOAD}, random_pc(), 3);
		send_word({12'h000, 5'd3, 3'd7, 5'd4, OPC_LOAD}, random_pc(), 3);
		send_word({7'h40, 5'd9, 5'd8, 3'd3, 5'd1, OPC_STORE}, random_pc(), 3);
		send_word({7'h00, 5'd9, 5'd8, 3'd4, 5'd1, OPC_STORE}, random_pc(), 3);
		send_word({1'b1, 6'h3F, 5'd2, 5'd1, 3'd7, 4'hF, 1'b1, OPC_BRANCH}, random_pc(), 3);
		send_word({12'h800, 5'd1, 3'd0, 5'd0, OPC_JALR}, random_pc(), 3);
		send_word({1'b1, 10'h000, 1'b0, 8'h00, 5'd31, OPC_JAL}, random_pc(), 3);
		send_word({20'hFFFFF, 5'd31, OPC_LUI}, random_pc(), 3);
		send_word({20'h00001, 5'd0, OPC_AUIPC}, random_pc(), 3);
		send_word({IMM_ECALL, 13'd0, OPC_SYSTEM}, random_pc(), 3);
		send_word({IMM_EBREAK, 13'd0, OPC_SYSTEM}, random_pc(), 3);
		send_word({IMM_ECALL, 5'd0, 3'd0, 5'd1, OPC_SYSTEM}, random_pc(), 3);
		send_word({IMM_EBREAK, 5'd1, 3'd0, 5'd0, OPC_SYSTEM}, random_pc(), 3);
		send_word({12'h002, 13'd0, OPC_SYSTEM}, random_pc(), 3);
	endtask

	task automatic test_every_operation();
		for (int k = OP_ADD; k <= OP_EBREAK; k++) send_word(make_word(op_t'(k)), random_pc(), 4);
	endtask

	// output held off while words keep coming, so both stages fill
	task automatic test_fill_and_stall();
		long_hold_req = 1'b1;
		repeat (16) send_word(make_word(op_t'($urandom_range(OP_ADD, OP_EBREAK))), random_pc(), 0);
		wait_drained();
	endtask

	task automatic test_pause_until_drained();
		repeat (12) send_word(make_word(op_t'($urandom_range(OP_ADD, OP_EBREAK))), random_pc(), 5);
		wait_drained();
		repeat (12) send_word(noise_word(), random_pc(), 5);
	endtask

	task automatic test_random_stream();
		int gap_odds;
		logic [31:0] w;
		for (int n = 0; n < 240; n++) begin
			if (n % 40 == 0) gap_odds = $urandom_range(0, 4);
			if ($urandom_range(0, 6) == 0) w = noise_word();
			else w = make_word(op_t'($urandom_range(OP_ADD, OP_EBREAK)));
			send_word(w, random_pc(), gap_odds);
		end
	endtask

	task automatic test_back_to_back();
		quiet = 1'b1;
		repeat (40) send_word(make_word(op_t'($urandom_range(OP_ADD, OP_EBREAK))), random_pc(), 0);
	endtask

	always @(negedge clk) begin
		if (long_hold_req) begin
			long_hold_left = LONG_HOLD_CYCLES;
			long_hold_req = 1'b0;
		end
		if (mode_cycles == 0) begin
			busy = ($urandom_range(0, 2) != 0);
			mode_cycles = 50;
		end else begin
			mode_cycles--;
		end
		if (long_hold_left > 0) begin
			out_ready <= 1'b0;
			long_hold_left--;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else if (!quiet && busy && $urandom_range(0, 5) == 0) begin
			out_ready <= 1'b0;
			stall_left = $urandom_range(1, 12) - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		decode_t want;
		if (arst_n) begin
			if (in_valid && !in_ready) input_stalls++;
			if (out_valid && !out_ready) output_stalls++;
		end
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (pending_decodes.size() == 0) begin
				report_mismatch("unexpected result, raw word", raw_out, '0);
			end else begin
				want = pending_decodes.pop_front();
				if (operation !== want.operation)
					report_mismatch("operation", operation, want.operation);
				if (register_count !== want.register_count)
					report_mismatch("register_count", register_count, want.register_count);
				if (reg_slot_a !== want.slot_a) report_mismatch("reg_slot_a", reg_slot_a, want.slot_a);
				if (reg_slot_b !== want.slot_b) report_mismatch("reg_slot_b", reg_slot_b, want.slot_b);
				if (reg_slot_c !== want.slot_c) report_mismatch("reg_slot_c", reg_slot_c, want.slot_c);
				if (has_immediate !== want.has_imm)
					report_mismatch("has_immediate", has_immediate, want.has_imm);
				if ($unsigned(immediate) !== want.immediate)
					report_mismatch("immediate", $unsigned(immediate), want.immediate);
				if (pc_out !== want.pc) report_mismatch("pc_out", pc_out, want.pc);
				if (raw_out !== want.raw) report_mismatch("raw_out", raw_out, want.raw);
				if (decoded_total !== want.decoded_total)
					report_mismatch("decoded_total", decoded_total, want.decoded_total);
				if (invalid_total !== want.invalid_total)
					report_mismatch("invalid_total", invalid_total, want.invalid_total);
				ops_seen[want.operation] = 1'b1;
				if (want.operation == OP_INVALID) invalid_results++;
				results_checked++;
			end
		end
	end

	initial begin
		int spin;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_every_operation();
		test_fill_and_stall();
		test_pause_until_drained();
		test_random_stream();
		test_back_to_back();
		in_valid <= 1'b0;
		for (spin = 0; spin < 5000 && pending_decodes.size() != 0; spin++) @(negedge clk);
		repeat (6) @(negedge clk);
		if (pending_decodes.size() != 0)
			report_mismatch("results never delivered", pending_decodes.size(), '0);
		$display("%0d words checked, %0d invalid, %0d of 51 operations seen", results_checked,
			invalid_results, $countones(ops_seen[51:1]));
		$display("input stalled %0d cycles, output held off %0d cycles", input_stalls,
			output_stalls);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
